>>> sv/prs_pkg.sv
package prs_pkg;

  // Sizes
  localparam int TASKS       = 16;
  localparam int LEVELS      = 4;
  localparam int UNAGED_LVLS = 1;
  localparam int TASK_W      = 4;
  localparam int LVL_W       = 2;
  localparam int FILL_W      = 5;
  localparam int SLOT_W      = LVL_W + TASK_W;
  localparam int CNT_W       = 16;
  localparam int QNT_W       = 8;
  localparam int OP_W        = 3;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  typedef logic [TASK_W-1:0] task_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [FILL_W-1:0] fill_t;
  typedef logic [SLOT_W-1:0] slot_t;

  localparam task_t IDLE_TASK      = TASK_W'(0);
  localparam task_t PROTECTED_TASK = TASK_W'(1);
  localparam lvl_t  LVL_TOP        = LVL_W'(LEVELS - 1);
  localparam lvl_t  LVL_AGE_TOP    = LVL_W'(LEVELS - 1 - UNAGED_LVLS);
  localparam fill_t FILL_MAX       = FILL_W'(TASKS);

  localparam logic [QNT_W-1:0] QUANTUM_RST = QNT_W'(5);
  localparam logic [CNT_W-1:0] AGING_RST   = CNT_W'(10);
  localparam logic [CNT_W-1:0] WAIT_SAT    = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_AGING   = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 3'd0,
    OP_READY   = 3'd1,
    OP_BLOCK   = 3'd2,
    OP_UNBLOCK = 3'd3,
    OP_TERM    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_ABSENT     = 3'd0,
    ST_READY      = 3'd1,
    ST_RUNNING    = 3'd2,
    ST_BLOCKED    = 3'd3,
    ST_TERMINATED = 3'd4
  } task_st_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SCAN_INIT, S_SCAN_RD, S_SCAN_EV, S_SCAN_END, S_SCAN_NEXT,
    S_POST, S_QUANT, S_PASS_CHK, S_PASS_RD, S_PASS_EV, S_DONE
  } ctl_state_e;

  typedef enum logic [3:0] {
    DP_NONE, DP_LOAD, DP_DECODE, DP_SCAN_INIT, DP_SCAN_RD, DP_SCAN_EV, DP_SCAN_END,
    DP_SCAN_NEXT, DP_POST, DP_QUANT, DP_PASS_CHK, DP_PASS_RD, DP_PASS_EV, DP_OUT
  } dp_op_e;

  typedef enum logic {
    SCAN_AGE,
    SCAN_UNLINK
  } scan_mode_e;

  typedef struct packed {
    dp_op_e op;
    logic   unlink;
  } prs_cmd_t;

  typedef struct packed {
    logic refuse;
    logic is_tick;
    logic is_bt;
    logic is_block;
    logic needs_unlink;
    logic lvl_empty;
    logic scan_last;
    logic age_last;
    logic spend;
    logic pass_bottom;
    logic pass_hit;
    logic run_hit;
    logic out_free;
  } prs_sts_t;

  // Queue slot address: level row, ring position head + offset
  function automatic slot_t slot_addr(lvl_t l, task_t head, fill_t off);
    task_t pos;
    pos = head + off[TASK_W-1:0];
    return {l, pos};
  endfunction

endpackage

>>> sv/prs_ifs.sv
interface prs_in_if;
  import prs_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [TASK_W-1:0]   task_id;
  logic [LVL_W-1:0]    level;
  modport source (output valid, opcode, task_id, level, input ready);
  modport sink   (input valid, opcode, task_id, level, output ready);
endinterface

interface prs_out_if;
  import prs_pkg::*;
  logic              valid;
  logic              ready;
  logic [TASK_W-1:0] current_task;
  logic              switched;
  logic              status;
  modport source (output valid, current_task, switched, status, input ready);
  modport sink   (input valid, current_task, switched, status, output ready);
endinterface

interface prs_cfg_if;
  import prs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/prs_dp.sv
module prs_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  prs_pkg::prs_cmd_t                cmd_i,
  output prs_pkg::prs_sts_t                sts_o,
  input  logic [prs_pkg::OP_W-1:0]         opcode_i,
  input  prs_pkg::task_t                   task_id_i,
  input  prs_pkg::lvl_t                    level_i,
  input  logic                             cfg_valid_i,
  input  logic [prs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [prs_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output prs_pkg::task_t                   current_task_o,
  output logic                             switched_o,
  output logic                             status_o
);
  import prs_pkg::*;

  // Event registers
  logic [OP_W-1:0] op_q;
  task_t           id_q;
  lvl_t            lv_q;

  // Per-task state
  task_st_e         status_q [TASKS];
  lvl_t             level_q  [TASKS];
  logic [CNT_W-1:0] wait_q   [TASKS];

  // Queue bookkeeping and slot memory
  task_t head_q [LEVELS];
  fill_t fill_q [LEVELS];
  task_t slots  [TASKS*LEVELS];

  task_t            run_q;
  logic [QNT_W-1:0] qleft_q, qticks_q;
  logic [CNT_W-1:0] alimit_q;

  // Scan counters and read data
  lvl_t  lvl_q;
  fill_t i_q, k_q, n_q;
  task_t rd_q;
  logic  sw_q, refused_q;

  logic  out_valid_q, out_sw_q, out_st_q;
  task_t out_task_q;

  task_st_e         st_id, st_v;
  lvl_t             lvl_id, lv_sat;
  logic             id_ok, refuse, elig, promote, live, spend;
  logic [CNT_W-1:0] winc;
  task_t            v, r;
  logic             push_en, push_ok, compact_en, mem_we, rd_en;
  lvl_t             push_lvl;
  task_t            push_task;
  slot_t            mem_wa, rd_a;
  task_t            mem_wd;

  assign st_id  = status_q[id_q];
  assign lvl_id = level_q[id_q];
  assign id_ok  = id_q != IDLE_TASK;
  assign lv_sat = (level_i > LVL_TOP) ? LVL_TOP : level_i;

  // Refusal rules per opcode
  always_comb begin
    unique case (op_q)
      OP_TICK:    refuse = 1'b0;
      OP_READY:   refuse = !id_ok || !(st_id == ST_ABSENT || st_id == ST_TERMINATED);
      OP_BLOCK:   refuse = !id_ok || id_q == PROTECTED_TASK || st_id == ST_ABSENT ||
                           st_id == ST_BLOCKED || st_id == ST_TERMINATED;
      OP_UNBLOCK: refuse = !id_ok || id_q == PROTECTED_TASK || st_id != ST_BLOCKED;
      OP_TERM:    refuse = !id_ok || st_id == ST_ABSENT || st_id == ST_TERMINATED;
      default:    refuse = 1'b1;
    endcase
  end

  // Entry just read from a queue
  assign v       = rd_q;
  assign st_v    = status_q[v];
  assign elig    = v != IDLE_TASK && st_v == ST_READY;
  assign winc    = (wait_q[v] == WAIT_SAT) ? WAIT_SAT : wait_q[v] + CNT_W'(1);
  assign promote = elig && winc >= alimit_q;

  // Running task quantum
  assign r     = run_q;
  assign live  = r != IDLE_TASK && status_q[r] == ST_RUNNING;
  assign spend = live && qleft_q > QNT_W'(1);

  // Tail pushes
  always_comb begin
    push_en   = 1'b0;
    push_lvl  = lv_q;
    push_task = id_q;
    case (cmd_i.op)
      DP_DECODE: begin
        if (!refuse && op_q == OP_READY) begin
          push_en = 1'b1;
        end else if (!refuse && op_q == OP_UNBLOCK) begin
          push_en  = 1'b1;
          push_lvl = lvl_id;
        end
      end
      DP_SCAN_EV: begin
        if (!cmd_i.unlink && promote) begin
          push_en   = 1'b1;
          push_lvl  = LVL_TOP;
          push_task = v;
        end
      end
      DP_QUANT: begin
        if (live && !spend) begin
          push_en   = 1'b1;
          push_lvl  = level_q[r];
          push_task = r;
        end
      end
      default: push_en = 1'b0;
    endcase
  end

  assign push_ok    = push_en && fill_q[push_lvl] < FILL_MAX;
  assign compact_en = cmd_i.op == DP_SCAN_EV && (cmd_i.unlink ? v != id_q : !promote);
  assign mem_we     = push_ok || compact_en;
  assign mem_wa     = compact_en ? slot_addr(lvl_q, head_q[lvl_q], k_q)
                                 : slot_addr(push_lvl, head_q[push_lvl], fill_q[push_lvl]);
  assign mem_wd     = compact_en ? v : push_task;
  assign rd_en      = cmd_i.op == DP_SCAN_RD || cmd_i.op == DP_PASS_RD;
  assign rd_a       = slot_addr(lvl_q, head_q[lvl_q],
                                (cmd_i.op == DP_SCAN_RD) ? i_q : '0);

  // Slot memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slots[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= slots[rd_a];
    end
  end

  // Scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < TASKS; t++) begin
        status_q[t] <= ST_ABSENT;
        level_q[t]  <= '0;
        wait_q[t]   <= '0;
      end
      for (int q = 0; q < LEVELS; q++) begin
        head_q[q] <= '0;
        fill_q[q] <= '0;
      end
      run_q     <= IDLE_TASK;
      qleft_q   <= QUANTUM_RST;
      qticks_q  <= QUANTUM_RST;
      alimit_q  <= AGING_RST;
      lvl_q     <= '0;
      i_q       <= '0;
      k_q       <= '0;
      n_q       <= '0;
      sw_q      <= 1'b0;
      refused_q <= 1'b0;
      op_q      <= '0;
      id_q      <= '0;
      lv_q      <= '0;
    end else begin
      case (cmd_i.op)
        DP_LOAD: begin
          op_q <= opcode_i;
          id_q <= task_id_i;
          lv_q <= lv_sat;
        end
        DP_DECODE: begin
          refused_q <= refuse;
          sw_q      <= 1'b0;
          lvl_q     <= (op_q == OP_TICK) ? '0 : lvl_id;
          if (!refuse && op_q == OP_READY) begin
            level_q[id_q]  <= lv_q;
            wait_q[id_q]   <= '0;
            status_q[id_q] <= ST_READY;
          end else if (!refuse && op_q == OP_UNBLOCK) begin
            status_q[id_q] <= ST_READY;
          end
        end
        DP_SCAN_INIT: begin
          n_q <= fill_q[lvl_q];
          i_q <= '0;
          k_q <= '0;
        end
        DP_SCAN_EV: begin
          i_q <= i_q + FILL_W'(1);
          if (compact_en) begin
            k_q <= k_q + FILL_W'(1);
          end
          if (!cmd_i.unlink) begin
            if (promote) begin
              wait_q[v]  <= '0;
              level_q[v] <= LVL_TOP;
            end else if (elig) begin
              wait_q[v] <= winc;
            end
          end
        end
        DP_SCAN_END:  fill_q[lvl_q] <= k_q;
        DP_SCAN_NEXT: lvl_q <= lvl_q + LVL_W'(1);
        DP_POST: begin
          lvl_q <= '0;
          if (op_q == OP_BLOCK) begin
            status_q[id_q] <= ST_BLOCKED;
            wait_q[id_q]   <= '0;
          end else begin
            status_q[id_q] <= ST_TERMINATED;
            if (run_q == id_q) begin
              run_q <= IDLE_TASK;
            end
          end
        end
        DP_QUANT: begin
          lvl_q <= LVL_TOP;
          if (spend) begin
            qleft_q <= qleft_q - QNT_W'(1);
          end else if (live) begin
            status_q[r] <= ST_READY;
          end
        end
        DP_PASS_CHK: begin
          if (fill_q[lvl_q] == '0) begin
            if (lvl_q == '0) begin
              run_q   <= IDLE_TASK;
              qleft_q <= qticks_q;
              sw_q    <= 1'b1;
            end else begin
              lvl_q <= lvl_q - LVL_W'(1);
            end
          end
        end
        DP_PASS_RD: begin
          head_q[lvl_q] <= head_q[lvl_q] + TASK_W'(1);
          fill_q[lvl_q] <= fill_q[lvl_q] - FILL_W'(1);
        end
        DP_PASS_EV: begin
          if (elig) begin
            status_q[v] <= ST_RUNNING;
            wait_q[v]   <= '0;
            run_q       <= v;
            qleft_q     <= qticks_q;
            sw_q        <= 1'b1;
          end
        end
        default: ;
      endcase
      if (push_ok) begin
        fill_q[push_lvl] <= fill_q[push_lvl] + FILL_W'(1);
      end
      // Register writes
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_QUANTUM) begin
          qticks_q <= cfg_data_i[QNT_W-1:0];
        end else if (cfg_index_i == CFG_AGING) begin
          alimit_q <= cfg_data_i;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_OUT) begin
      out_task_q <= run_q;
      out_sw_q   <= sw_q;
      out_st_q   <= refused_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign current_task_o = out_task_q;
  assign switched_o     = out_sw_q;
  assign status_o       = out_st_q;

  // Status to controller
  assign sts_o.refuse       = refuse;
  assign sts_o.is_tick      = op_q == OP_TICK;
  assign sts_o.is_bt        = op_q == OP_BLOCK || op_q == OP_TERM;
  assign sts_o.is_block     = op_q == OP_BLOCK;
  assign sts_o.needs_unlink = st_id == ST_READY;
  assign sts_o.lvl_empty    = fill_q[lvl_q] == '0;
  assign sts_o.scan_last    = (i_q + FILL_W'(1)) == n_q;
  assign sts_o.age_last     = lvl_q == LVL_AGE_TOP;
  assign sts_o.spend        = spend;
  assign sts_o.pass_bottom  = lvl_q == '0;
  assign sts_o.pass_hit     = elig;
  assign sts_o.run_hit      = run_q == id_q;
  assign sts_o.out_free     = !out_valid_q || out_ready_i;

endmodule

>>> sv/prs_ctrl.sv
module prs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  prs_pkg::prs_sts_t sts_i,
  output prs_pkg::prs_cmd_t cmd_o
);
  import prs_pkg::*;

  ctl_state_e state_q, state_d;
  scan_mode_e mode_q, mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= SCAN_AGE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    cmd_o.op      = DP_NONE;
    cmd_o.unlink  = mode_q == SCAN_UNLINK;
    in_ready_o    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = DP_LOAD;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.op = DP_DECODE;
        if (sts_i.refuse) begin
          state_d = S_DONE;
        end else if (sts_i.is_tick) begin
          mode_d  = SCAN_AGE;
          state_d = S_SCAN_INIT;
        end else if (sts_i.is_bt) begin
          mode_d  = SCAN_UNLINK;
          state_d = sts_i.needs_unlink ? S_SCAN_INIT : S_POST;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCAN_INIT: begin
        cmd_o.op = DP_SCAN_INIT;
        state_d  = sts_i.lvl_empty ? S_SCAN_NEXT : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.op = DP_SCAN_RD;
        state_d  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd_o.op = DP_SCAN_EV;
        state_d  = sts_i.scan_last ? S_SCAN_END : S_SCAN_RD;
      end
      S_SCAN_END: begin
        cmd_o.op = DP_SCAN_END;
        state_d  = S_SCAN_NEXT;
      end
      S_SCAN_NEXT: begin
        cmd_o.op = DP_SCAN_NEXT;
        if (mode_q == SCAN_UNLINK) begin
          state_d = S_POST;
        end else begin
          state_d = sts_i.age_last ? S_QUANT : S_SCAN_INIT;
        end
      end
      S_POST: begin
        cmd_o.op = DP_POST;
        if (sts_i.is_block && sts_i.run_hit) begin
          mode_d  = SCAN_AGE;
          state_d = S_SCAN_INIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_QUANT: begin
        cmd_o.op = DP_QUANT;
        state_d  = sts_i.spend ? S_DONE : S_PASS_CHK;
      end
      S_PASS_CHK: begin
        cmd_o.op = DP_PASS_CHK;
        if (!sts_i.lvl_empty) begin
          state_d = S_PASS_RD;
        end else if (sts_i.pass_bottom) begin
          state_d = S_DONE;
        end
      end
      S_PASS_RD: begin
        cmd_o.op = DP_PASS_RD;
        state_d  = S_PASS_EV;
      end
      S_PASS_EV: begin
        cmd_o.op = DP_PASS_EV;
        state_d  = sts_i.pass_hit ? S_DONE : S_PASS_CHK;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = DP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> sv/priority_rr_scheduler_aging_unit.sv
// Multilevel round-robin task scheduler with aging: one event beat in, one result beat out.
// Work is sequenced one event at a time by a controller over a queue slot memory with one
// write port and one registered read port, so each event is finished before the next is
// accepted. Block or terminate of a queued task first scans its queue to unlink it; a tick
// ages the waiting tasks in the lower levels and, once the quantum runs out, runs a pass that
// searches the levels and pops queue entries; blocking the running task adds a tick's
// sequence. The result register frees the input side, so the next event is taken while a
// result waits. Configuration writes are always ready.
module priority_rr_scheduler_aging_unit (
  input logic       clk_i,
  input logic       rst_ni,
  prs_in_if.sink    in_if,
  prs_out_if.source out_if,
  prs_cfg_if.sink   cfg_if
);
  import prs_pkg::*;

  prs_cmd_t cmd;
  prs_sts_t sts;

  assign cfg_if.ready = 1'b1;

  prs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (in_if.opcode),
    .task_id_i      (in_if.task_id),
    .level_i        (in_if.level),
    .cfg_valid_i    (cfg_if.valid),
    .cfg_index_i    (cfg_if.index),
    .cfg_data_i     (cfg_if.data),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .current_task_o (out_if.current_task),
    .switched_o     (out_if.switched),
    .status_o       (out_if.status)
  );

  // One event in flight: after an input beat the input side closes
  a_one_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input taken while an event is in flight");

  // A result beat only appears after the controller loads the result register
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> $past(cmd.op == DP_OUT))
    else $error("result valid without a load");

  // A refused event never reports a scheduling pass
  a_refused_no_switch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.status |-> !out_if.switched)
    else $error("refused event reports a switch");

endmodule

>>> test/prs_sched_checker.sv
`timescale 1ns / 1ps

// Watches the event, result and register channels, tracks the scheduler state and
// compares every result beat with the oldest prediction.
module prs_sched_checker (
  input logic  clk_i,
  input logic  rst_ni,
  prs_in_if    in_if,
  prs_out_if   out_if,
  prs_cfg_if   cfg_if,
  output int   err_cnt_o,
  output int   pending_o,
  output int   result_cnt_o
);
  import prs_pkg::*;

  typedef struct packed {
    task_t cur;
    logic  sw;
    logic  st;
  } sched_res_t;

  task_st_e         tst [TASKS];
  lvl_t             tlvl [TASKS];
  logic [CNT_W-1:0] twait [TASKS];
  task_t            rq [LEVELS][$];
  task_t            run_id;
  logic [QNT_W-1:0] qleft;
  logic [QNT_W-1:0] quantum_reg;
  logic [CNT_W-1:0] aging_reg;
  sched_res_t       sched_q[$];

  assign pending_o = sched_q.size();

  // Drop one task from a level queue, keeping order
  function automatic void drop_task(int l, task_t t);
    task_t keep[$];
    for (int i = 0; i < rq[l].size(); i++) if (rq[l][i] != t) keep.push_back(rq[l][i]);
    rq[l] = keep;
  endfunction

  // Aging walk over the lower levels, then quantum, then a pass
  function automatic logic sched_call();
    task_t keep[$];
    task_t v;
    task_t r;
    r = run_id;
    for (int l = 0; l <= LEVELS - 1 - UNAGED_LVLS; l++) begin
      keep.delete();
      for (int i = 0; i < rq[l].size(); i++) begin
        v = rq[l][i];
        if (v != IDLE_TASK && tst[v] == ST_READY) begin
          if (twait[v] != WAIT_SAT) twait[v]++;
          if (twait[v] >= aging_reg) begin
            twait[v] = '0;
            tlvl[v] = LVL_TOP;
            rq[LEVELS-1].push_back(v);
            continue;
          end
        end
        keep.push_back(v);
      end
      rq[l] = keep;
    end
    if (r != IDLE_TASK && tst[r] == ST_RUNNING) begin
      if (qleft > 1) begin
        qleft--;
        return 1'b0;
      end
      tst[r] = ST_READY;
      rq[tlvl[r]].push_back(r);
    end
    for (int l = LEVELS - 1; l >= 0; l--) begin
      while (rq[l].size() > 0) begin
        v = rq[l].pop_front();
        if (v != IDLE_TASK && tst[v] == ST_READY) begin
          tst[v] = ST_RUNNING;
          twait[v] = '0;
          run_id = v;
          qleft = quantum_reg;
          return 1'b1;
        end
      end
    end
    run_id = IDLE_TASK;
    qleft = quantum_reg;
    return 1'b1;
  endfunction

  function automatic sched_res_t predict_event(logic [OP_W-1:0] op, task_t id, lvl_t lv);
    sched_res_t res;
    task_st_e   st;
    logic       ok;
    res = '0;
    ok = (id != IDLE_TASK);
    st = ok ? tst[id] : ST_ABSENT;
    case (op)
      OP_TICK: res.sw = sched_call();
      OP_READY: begin
        if (!ok || (st != ST_ABSENT && st != ST_TERMINATED)) res.st = 1'b1;
        else begin
          tlvl[id] = lv;
          twait[id] = '0;
          tst[id] = ST_READY;
          rq[lv].push_back(id);
        end
      end
      OP_BLOCK: begin
        if (!ok || id == PROTECTED_TASK || st == ST_ABSENT || st == ST_BLOCKED ||
            st == ST_TERMINATED) res.st = 1'b1;
        else begin
          if (st == ST_READY) drop_task(tlvl[id], id);
          tst[id] = ST_BLOCKED;
          twait[id] = '0;
          if (run_id == id) res.sw = sched_call();
        end
      end
      OP_UNBLOCK: begin
        if (!ok || id == PROTECTED_TASK || st != ST_BLOCKED) res.st = 1'b1;
        else begin
          tst[id] = ST_READY;
          rq[tlvl[id]].push_back(id);
        end
      end
      OP_TERM: begin
        if (!ok || st == ST_ABSENT || st == ST_TERMINATED) res.st = 1'b1;
        else begin
          if (st == ST_READY) drop_task(tlvl[id], id);
          tst[id] = ST_TERMINATED;
          if (run_id == id) run_id = IDLE_TASK;
        end
      end
      default: res.st = 1'b1;
    endcase
    res.cur = run_id;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t got;
    sched_res_t exp_r;
    if (!rst_ni) begin
      foreach (tst[i]) begin
        tst[i] = ST_ABSENT;
        tlvl[i] = '0;
        twait[i] = '0;
      end
      foreach (rq[l]) rq[l].delete();
      sched_q.delete();
      run_id = IDLE_TASK;
      quantum_reg = QUANTUM_RST;
      aging_reg = AGING_RST;
      qleft = QUANTUM_RST;
      err_cnt_o = 0;
      result_cnt_o = 0;
    end else begin
      // register writes
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == CFG_QUANTUM) quantum_reg = cfg_if.data[QNT_W-1:0];
        else if (cfg_if.index == CFG_AGING) aging_reg = cfg_if.data;
      end
      // result beat against the oldest prediction
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.current_task, out_if.switched, out_if.status};
        result_cnt_o++;
        if (sched_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %h", $time, got);
          err_cnt_o++;
        end else begin
          exp_r = sched_q.pop_front();
          if (got.cur !== exp_r.cur || got.sw !== exp_r.sw || got.st !== exp_r.st) begin
            $display("%0t: expected task %0d sw %0d st %0d, actual task %0d sw %0d st %0d",
                     $time, exp_r.cur, exp_r.sw, exp_r.st, got.cur, got.sw, got.st);
            err_cnt_o++;
          end
        end
      end
      // event beat
      if (in_if.valid && in_if.ready)
        sched_q.push_back(predict_event(in_if.opcode, in_if.task_id, in_if.level));
    end
  end

endmodule

>>> test/tb_priority_rr_scheduler_aging_unit.sv
`timescale 1ns / 1ps

module tb_priority_rr_scheduler_aging_unit;
  import prs_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   err_cnt;
  int   pending;
  int   result_cnt;
  int   cycle_cnt = 0;
  int   sent = 0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  logic hold_rcv = 1'b0;

  localparam int CYCLE_LIMIT = 800000;

  prs_in_if  in_if ();
  prs_out_if out_if ();
  prs_cfg_if cfg_if ();

  priority_rr_scheduler_aging_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  prs_sched_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_if      (cfg_if),
    .err_cnt_o   (err_cnt),
    .pending_o   (pending),
    .result_cnt_o(result_cnt)
  );

  always #1 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("priority_rr_scheduler_aging_unit: mismatch");
      $finish;
    end
  end

  // Result side stalls
  always @(posedge clk_i) begin
    out_if.ready <= !hold_rcv && ($urandom_range(99) >= rcv_idle_pct);
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.task_id = '0;
    in_if.level = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
  end

  // One event beat, waiting on the handshake
  task automatic send_event(logic [OP_W-1:0] op, task_t id, lvl_t lv);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.task_id <= id;
    in_if.level <= lv;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly legal opcodes: ready sets, ticks, block/unblock/terminate of random task ids
  task automatic random_events(int n);
    int r;
    logic [OP_W-1:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 40) op = OP_TICK;
      else if (r < 60) op = OP_READY;
      else if (r < 74) op = OP_BLOCK;
      else if (r < 88) op = OP_UNBLOCK;
      else if (r < 97) op = OP_TERM;
      else op = 3'($urandom_range(7, 5));
      send_event(op, 4'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed: every opcode, protected and idle ids, level extremes
    write_reg(CFG_QUANTUM, 16'd2);
    write_reg(CFG_AGING, 16'd3);
    send_event(OP_TICK, 4'd0, 2'd0);
    send_event(OP_READY, IDLE_TASK, 2'd3);
    send_event(OP_READY, PROTECTED_TASK, 2'd0);
    send_event(OP_READY, 4'd15, 2'd3);
    send_event(OP_READY, 4'd15, 2'd1);
    send_event(OP_READY, 4'd2, 2'd0);
    send_event(OP_READY, 4'd3, 2'd2);
    send_event(OP_TICK, 4'd0, 2'd0);
    send_event(OP_BLOCK, PROTECTED_TASK, 2'd0);
    send_event(OP_UNBLOCK, PROTECTED_TASK, 2'd0);
    send_event(OP_BLOCK, 4'd15, 2'd0);
    send_event(OP_BLOCK, 4'd15, 2'd0);
    send_event(OP_UNBLOCK, 4'd15, 2'd0);
    send_event(OP_UNBLOCK, 4'd2, 2'd0);
    send_event(OP_TICK, 4'd0, 2'd0);
    send_event(OP_TICK, 4'd0, 2'd0);
    send_event(OP_TICK, 4'd0, 2'd0);
    send_event(OP_TERM, 4'd3, 2'd0);
    send_event(OP_TERM, 4'd3, 2'd0);
    send_event(OP_TERM, 4'd9, 2'd0);
    send_event(OP_READY, 4'd3, 2'd1);
    send_event(3'd7, 4'd5, 2'd2);
    send_event(3'd5, 4'd10, 2'd1);
    send_event(OP_TICK, 4'd0, 2'd0);
    drain();

    // Phase 1: sender idles a little, receiver a lot
    write_reg(CFG_QUANTUM, 16'd255);
    write_reg(CFG_AGING, 16'd1);
    snd_idle_pct = 8;
    rcv_idle_pct = 64;
    random_events(450);
    drain();

    // Long receiver hold while events keep coming
    write_reg(CFG_QUANTUM, 16'd1);
    write_reg(CFG_AGING, 16'd65535);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    fork
      begin
        hold_rcv = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_rcv = 1'b0;
      end
      random_events(40);
    join
    drain();

    // Phase 2: the other way round
    write_reg(CFG_QUANTUM, 16'd3);
    write_reg(CFG_AGING, 16'd6);
    snd_idle_pct = 64;
    rcv_idle_pct = 8;
    random_events(450);
    drain();

    // Phase 3: no idling, zero quantum counts as one
    write_reg(CFG_QUANTUM, 16'd0);
    write_reg(CFG_AGING, 16'd2);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_events(490);
    drain();

    $display("sent %0d events, checked %0d results across quantum 0..255 and aging 1..65535",
             sent, result_cnt);
    if (err_cnt == 0) begin
      $display("priority_rr_scheduler_aging_unit: match");
    end else begin
      $display("priority_rr_scheduler_aging_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
sv/prs_pkg.sv
sv/prs_ifs.sv
sv/prs_dp.sv
sv/prs_ctrl.sv
sv/priority_rr_scheduler_aging_unit.sv
test/prs_sched_checker.sv
test/tb_priority_rr_scheduler_aging_unit.sv
